>>> src/dctt_pkg.sv
// ----------------------------------------------------------------------------
// dctt_pkg: shared definitions for the decaying cell trace block
// Sizes, request and register codes, reset values and the store request.
// ----------------------------------------------------------------------------
package dctt_pkg;

  localparam int CELLS   = 64;
  localparam int CIDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ADDR_W  = CIDX_W + 1;        // {trace, cell}
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int LVL_W   = 16;                // Q1.15 level
  localparam int FRAC_W  = 15;
  localparam int CELL_FW = 6;                 // cell_index / out_cell field
  localparam int REQ_W   = 2;
  localparam int CFG_AW  = 2;

  localparam logic [REQ_W-1:0] REQ_STEP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_DECAY   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_THRESH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_REFRESH = 2'd2;

  localparam logic [LVL_W-1:0] DECAY_RST   = 16'd32768;
  localparam logic [LVL_W-1:0] THRESH_RST  = 16'd16384;
  localparam logic [LVL_W-1:0] REFRESH_RST = 16'd32768;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LVL_W-1:0]  wr_data;
  } dctt_mem_req_t;

endpackage

>>> src/dctt_store.sv
// ----------------------------------------------------------------------------
// dctt_store: level store for both traces
// One write port, one registered read port; per-entry valid bits make
// never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module dctt_store
  import dctt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dctt_mem_req_t       req,
  output logic [LVL_W-1:0]    rd_level
);

  logic [LVL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [LVL_W-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rdata_r <= mem[req.rd_addr];
    rvld_r  <= vld_r[req.rd_addr];
  end

  assign rd_level = rvld_r ? rdata_r : '0;

endmodule

>>> src/dctt_scale.sv
// ----------------------------------------------------------------------------
// dctt_scale: shared decay multiplier
// Registered level * rate product, then >>15 with saturation to 16 bits.
// ----------------------------------------------------------------------------
module dctt_scale
  import dctt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [ADDR_W-1:0]    in_addr,
  input  logic [LVL_W-1:0]     in_level,
  input  logic [LVL_W-1:0]     rate,
  output logic                 out_vld,
  output logic [ADDR_W-1:0]    out_addr,
  output logic [LVL_W-1:0]     out_level
);

  logic [2*LVL_W-1:0]        prod_r;
  logic [ADDR_W-1:0]         addr_r;
  logic                      vld_r;
  logic [2*LVL_W-FRAC_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*LVL_W)'(in_level) * (2*LVL_W)'(rate);
    addr_r <= in_addr;
  end

  // anything above 16 bits only when rate > 1.0
  assign shifted   = prod_r[2*LVL_W-1:FRAC_W];
  assign out_level = (|shifted[2*LVL_W-FRAC_W-1:LVL_W]) ? {LVL_W{1'b1}}
                                                         : shifted[LVL_W-1:0];
  assign out_vld   = vld_r;
  assign out_addr  = addr_r;

endmodule

>>> src/decaying_cell_trace_threshold.sv
// ----------------------------------------------------------------------------
// decaying_cell_trace_threshold: two decaying Q1.15 cell traces with
// threshold report
// Sequencer around one level store and one shared decay multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request transfers. in_tuser = {which_trace, req_type}; in_tdata =
//           {pad, run_flag, cell_index}. in_tready is high only while idle.
//   out_* : one transfer per reported cell, tlast on the last of a dump;
//           out_tuser = {none_found, out_trace}, out_tdata = {pad, out_cell}.
//   cfg_* : write strobe, register index, 16-bit data; written while idle.
// Request handling (until the next request can be taken):
//   mark, ignored and early-dump requests: the sequencer stays idle.
//   begin-step: one store read per cell of both traces through the single
//     multiplier, each product written back; idle again once all are written.
//   dump: one cell compared per cycle while not stalled. A hit is held one
//     cell back so tlast can be set on the real last hit; the walk pauses
//     while a held hit cannot be sent.
// Reset (rst_n low, synchronous): both traces read as zero, run flag and
//   step-seen cleared, registers to their defaults, output empty.
// The output register is decoupled: a new request is taken while the
// final result of a dump still waits for out_tready.
// ----------------------------------------------------------------------------
module decaying_cell_trace_threshold
  import dctt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [5:0] cell_index, [6] run_flag
  input  logic [2:0]          in_tuser,   // [1:0] req_type, [2] which_trace
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [5:0] out_cell
  output logic [1:0]          out_tuser,  // [0] out_trace, [1] none_found
  output logic                out_tlast,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [LVL_W-1:0]    cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DECAY = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;
  localparam logic [1:0] S_DFIN  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);

  // input fields
  logic [REQ_W-1:0]   req_type;
  logic               which_trace;
  logic [CELL_FW-1:0] cell_index;
  logic               run_flag;

  assign req_type    = in_tuser[1:0];
  assign which_trace = in_tuser[2];
  assign cell_index  = in_tdata[5:0];
  assign run_flag    = in_tdata[6];

  // configuration registers
  logic [LVL_W-1:0] rate_r, thr_r, refr_r;

  // sequencer state
  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               trc_r, trc_nxt;
  logic               d_vld_r, d_vld_nxt;      // store read in flight
  logic [ADDR_W-1:0]  d_addr_r, d_addr_nxt;
  logic               pend_vld_r, pend_vld_nxt; // held hit
  logic [CIDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic               step_seen_r, step_seen_nxt;
  logic               run_r, run_nxt;

  // output register
  logic               out_vld_r, out_vld_nxt;
  logic               out_trc_r, out_trc_nxt;
  logic [CELL_FW-1:0] out_cell_r, out_cell_nxt;
  logic               out_none_r, out_none_nxt;
  logic               out_last_r, out_last_nxt;

  // datapath links
  dctt_mem_req_t      mreq;
  logic [LVL_W-1:0]   level;
  logic               sc_vld;
  logic [ADDR_W-1:0]  sc_addr;
  logic [LVL_W-1:0]   sc_level;

  logic               in_xfer;
  logic               issuing;
  logic               hit;
  logic               push_ok;
  logic               stall;
  logic               mark_wr;
  logic [ADDR_W-1:0]  walk_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign issuing   = (cnt_r < CNT_END);
  assign push_ok   = !out_vld_r || out_tready;
  assign hit       = d_vld_r && (level >= thr_r);
  assign stall     = (state_r == S_DUMP) && hit && pend_vld_r && !push_ok;
  assign walk_addr = {trc_r, cnt_r[CIDX_W-1:0]};
  assign mark_wr   = in_xfer && (req_type == REQ_MARK) && run_r &&
                     ({1'b0, cell_index} < (CELL_FW + 1)'(CELLS));

  // store port: reads follow the walk (or replay on stall); writes come
  // from the multiplier during decay, from a mark otherwise
  always_comb begin
    mreq.rd_addr = stall ? d_addr_r : walk_addr;
    if (sc_vld) begin
      mreq.wr_en   = 1'b1;
      mreq.wr_addr = sc_addr;
      mreq.wr_data = sc_level;
    end else begin
      mreq.wr_en   = mark_wr;
      mreq.wr_addr = {which_trace, cell_index[CIDX_W-1:0]};
      mreq.wr_data = refr_r;
    end
  end

  dctt_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .rd_level (level)
  );

  dctt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (d_vld_r && (state_r == S_DECAY)),
    .in_addr   (d_addr_r),
    .in_level  (level),
    .rate      (rate_r),
    .out_vld   (sc_vld),
    .out_addr  (sc_addr),
    .out_level (sc_level)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    trc_nxt       = trc_r;
    d_vld_nxt     = 1'b0;
    d_addr_nxt    = d_addr_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    step_seen_nxt = step_seen_r;
    run_nxt       = run_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_trc_nxt   = out_trc_r;
    out_cell_nxt  = out_cell_r;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (req_type == REQ_STEP) begin
            state_nxt     = S_DECAY;
            cnt_nxt       = '0;
            trc_nxt       = 1'b0;
            run_nxt       = run_flag;
            step_seen_nxt = 1'b1;
          end else if (req_type == REQ_DUMP && step_seen_r) begin
            state_nxt    = S_DUMP;
            cnt_nxt      = '0;
            trc_nxt      = which_trace;
            pend_vld_nxt = 1'b0;
          end
        end
      end

      S_DECAY: begin
        d_vld_nxt  = issuing;
        d_addr_nxt = walk_addr;
        if (issuing) begin
          if (cnt_r == CNT_LAST && !trc_r) begin
            cnt_nxt = '0;
            trc_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (!d_vld_r && !sc_vld) begin
          state_nxt = S_IDLE;
        end
      end

      S_DUMP: begin
        if (stall) begin
          d_vld_nxt = 1'b1;
        end else begin
          d_vld_nxt  = issuing;
          d_addr_nxt = walk_addr;
          if (issuing) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (hit) begin
            if (pend_vld_r) begin
              // a later hit exists, so the held one is not last
              out_vld_nxt  = 1'b1;
              out_trc_nxt  = trc_r;
              out_cell_nxt = CELL_FW'(pend_idx_r);
              out_none_nxt = 1'b0;
              out_last_nxt = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = d_addr_r[CIDX_W-1:0];
          end
          if (!issuing && !d_vld_r) begin
            state_nxt = S_DFIN;
          end
        end
      end

      S_DFIN: begin
        // final transfer: held hit with tlast, or the empty marker
        if (push_ok) begin
          out_vld_nxt  = 1'b1;
          out_trc_nxt  = trc_r;
          out_cell_nxt = pend_vld_r ? CELL_FW'(pend_idx_r) : '0;
          out_none_nxt = !pend_vld_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      trc_r       <= 1'b0;
      d_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      step_seen_r <= 1'b0;
      run_r       <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      trc_r       <= trc_nxt;
      d_vld_r     <= d_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      step_seen_r <= step_seen_nxt;
      run_r       <= run_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    d_addr_r   <= d_addr_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_trc_r  <= out_trc_nxt;
    out_cell_r <= out_cell_nxt;
    out_none_r <= out_none_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= DECAY_RST;
      thr_r  <= THRESH_RST;
      refr_r <= REFRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DECAY:   rate_r <= cfg_wdata;
        CFG_THRESH:  thr_r  <= cfg_wdata;
        CFG_REFRESH: refr_r <= cfg_wdata;
        default: ;   // unused index, write dropped
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8 - CELL_FW){1'b0}}, out_cell_r};
  assign out_tuser  = {out_none_r, out_trc_r};
  assign out_tlast  = out_last_r;

endmodule
